FILE: src/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; every module in src imports this package.
`default_nettype none

package mexp_pkg;

  // Operand width of the ports; every residue is one bit narrower (RES_W)
  localparam int DATA_W     = 32;
  localparam int RES_W      = DATA_W - 1;

  // Datapath width that sets how many exponent bit positions are scanned
  localparam int VALUE_BITS = 32;
  localparam int SCAN_STEPS = (VALUE_BITS - 1 > 63) ? 63 :
                              ((VALUE_BITS - 1 < 1) ? 1 : VALUE_BITS - 1);
  localparam int STEP_W     = $clog2(SCAN_STEPS + 1);

  // Iteration counter of the bit-serial modular multiplier
  localparam int CNT_W      = $clog2(RES_W);

  // Operation run by the shared modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULT,
    OP_SQUARE
  } mul_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t op;
    logic    shift;
    logic    emit_prod;
    logic    emit_zero;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic invalid;
    logic mul_busy;
    logic mul_done;
    logic exp_bit;
    logic last_step;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/mexp_mulmod.sv
// Bit-serial modular multiplier: result = a * y mod m, one bit of y per cycle.
// Depends on mexp_pkg; requires a <= m and m >= 1.
`default_nettype none

module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RES_W-1:0] op_a,
  input  wire logic [RES_W-1:0] op_y,
  input  wire logic [RES_W-1:0] mod,
  output logic                  busy,
  output logic                  done,
  output logic [RES_W-1:0]      result
);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RES_W-1:0] a_r;
  logic [RES_W-1:0] y_r;
  logic [RES_W-1:0] acc_r;
  logic [RES_W-1:0] acc_nxt;

  logic [RES_W+2:0] sum;
  logic [RES_W+2:0] m1;
  logic [RES_W+2:0] m2;
  logic [RES_W+2:0] diff1;
  logic [RES_W+2:0] diff2;

  // Double the accumulator, add the multiplicand on a set bit, fold below m
  always_comb begin
    sum   = {2'b00, acc_r, 1'b0} + (y_r[RES_W-1] ? {3'b000, a_r} : '0);
    m1    = {3'b000, mod};
    m2    = {2'b00, mod, 1'b0};
    diff1 = sum - m1;
    diff2 = sum - m2;
    priority if (sum >= m2) begin
      acc_nxt = diff2[RES_W-1:0];
    end else if (sum >= m1) begin
      acc_nxt = diff1[RES_W-1:0];
    end else begin
      acc_nxt = sum[RES_W-1:0];
    end
  end

  // Hold operands, advance one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      acc_r  <= '0;
      a_r    <= '0;
      y_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        acc_r <= '0;
        a_r   <= op_a;
        y_r   <= op_y;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        y_r   <= {y_r[RES_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RES_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy   = run_r;
  assign done   = done_r;
  assign result = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("mulmod restarted while running");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r))
    else $error("mulmod done without a preceding run");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < mod))
    else $error("mulmod result not below modulus");

endmodule

`default_nettype wire

FILE: src/mexp_datapath.sv
// Datapath: operand, square, product and exponent registers plus the shared multiplier.
// Depends on mexp_pkg and mexp_mulmod.
`default_nettype none

module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  input  wire logic signed [DATA_W-1:0] in_base,
  input  wire logic signed [DATA_W-1:0] in_exponent,
  input  wire logic signed [DATA_W-1:0] in_modulus,
  output dp_status_t                    status,
  output logic [RES_W-1:0]              residue
);

  logic [RES_W-1:0]  base_r;
  logic [RES_W-1:0]  mod_r;
  logic [RES_W-1:0]  sq_r;
  logic [RES_W-1:0]  prod_r;
  logic [RES_W-1:0]  exp_r;
  logic [STEP_W-1:0] step_r;
  logic [RES_W-1:0]  res_r;
  mul_op_t           op_r;

  logic [RES_W-1:0]  mul_a;
  logic [RES_W-1:0]  mul_y;
  logic              mul_busy;
  logic              mul_done;
  logic [RES_W-1:0]  mul_res;

  // Pick multiplier operands for the commanded operation
  always_comb begin
    unique case (cmd.op)
      OP_REDUCE: begin
        mul_a = RES_W'(1);
        mul_y = base_r;
      end
      OP_MULT: begin
        mul_a = sq_r;
        mul_y = prod_r;
      end
      OP_SQUARE: begin
        mul_a = sq_r;
        mul_y = sq_r;
      end
      default: begin
        mul_a = sq_r;
        mul_y = sq_r;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .op_a   (mul_a),
    .op_y   (mul_y),
    .mod    (mod_r),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  // Load operands, write back multiplier results, shift the exponent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      mod_r  <= '0;
      sq_r   <= '0;
      prod_r <= '0;
      exp_r  <= '0;
      step_r <= '0;
      res_r  <= '0;
      op_r   <= OP_REDUCE;
    end else begin
      if (cmd.load) begin
        base_r <= in_base[RES_W-1:0];
        mod_r  <= in_modulus[RES_W-1:0];
        exp_r  <= in_exponent[RES_W-1:0];
        step_r <= '0;
        prod_r <= (in_modulus[RES_W-1:0] == RES_W'(1)) ? '0 : RES_W'(1);
      end
      if (cmd.mul_start) begin
        op_r <= cmd.op;
      end
      if (mul_done) begin
        unique case (op_r)
          OP_MULT:   prod_r <= mul_res;
          OP_REDUCE: sq_r   <= mul_res;
          OP_SQUARE: sq_r   <= mul_res;
          default:   sq_r   <= mul_res;
        endcase
      end
      if (cmd.shift) begin
        exp_r  <= {1'b0, exp_r[RES_W-1:1]};
        step_r <= step_r + 1'b1;
      end
      if (cmd.emit_zero) begin
        res_r <= '0;
      end else if (cmd.emit_prod) begin
        res_r <= prod_r;
      end
    end
  end

  // Report operand validity, multiplier status, exponent bit and scan position
  always_comb begin
    status.invalid   = (in_base <= 0) || (in_modulus <= 0) || (in_exponent < 0);
    status.mul_busy  = mul_busy;
    status.mul_done  = mul_done;
    status.exp_bit   = exp_r[0];
    status.last_step = (step_r == STEP_W'(SCAN_STEPS));
  end

  assign residue = res_r;

endmodule

`default_nettype wire

FILE: src/mexp_ctrl.sv
// Controller FSM: sequences reduce, multiply and square steps over the exponent bits.
// Depends on mexp_pkg; drives the datapath only through dp_cmd_t.
`default_nettype none

module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_BIT,
    S_MUL_WAIT,
    S_SQR_WAIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    cmd.op        = OP_SQUARE;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (status.invalid) begin
            cmd.emit_zero = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_RED_GO;
          end
        end
      end
      S_RED_GO: begin
        cmd.mul_start = 1'b1;
        cmd.op        = OP_REDUCE;
        state_nxt     = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        if (status.mul_done) begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        priority if (status.last_step) begin
          cmd.emit_prod = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (status.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.op        = OP_MULT;
          state_nxt     = S_MUL_WAIT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = OP_SQUARE;
          state_nxt     = S_SQR_WAIT;
        end
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.op        = OP_SQUARE;
          state_nxt     = S_SQR_WAIT;
        end
      end
      S_SQR_WAIT: begin
        if (status.mul_done) begin
          cmd.shift = 1'b1;
          state_nxt = S_BIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !status.mul_busy)
    else $error("multiplier started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.mul_done |-> (state_r == S_RED_WAIT || state_r == S_MUL_WAIT ||
                         state_r == S_SQR_WAIT))
    else $error("multiplier done outside a wait state");

endmodule

`default_nettype wire

FILE: src/modular_exponentiation.sv
// Top level: residue = base ^ exponent mod modulus, right-to-left square and multiply.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   input    | in_base, in_exponent, in_modulus         | start high, busy low
//   result   | out_residue                             | out_valid, one-cycle beat
//
// Timing: an invalid operand set gives its result the cycle after the beat, with busy
// staying low. A valid item runs its modular multiplies in turn on the one shared
// bit-serial unit: one for the base reduction, one square per bit of exponent[30:0],
// one more per set bit. Reset is synchronous; the result beat cannot be stalled by
// the receiver.
`default_nettype none

module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_base,
  input  wire logic signed [DATA_W-1:0] in_exponent,
  input  wire logic signed [DATA_W-1:0] in_modulus,
  output logic                          out_valid,
  output logic [RES_W-1:0]              out_residue
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mexp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .in_modulus  (in_modulus),
    .status      (status),
    .residue     (out_residue)
  );

endmodule

`default_nettype wire
